>>> sv/ufp_pkg.sv
// Shared types and constants for the UART frame parser with XOR check.
// Used by uart_frame_parser_xor_fcs_top; depends on nothing else.
package ufp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned OUT_W     = 40;

  localparam logic [BYTE_W-1:0] LEN_FLOOR        = 8'd4;
  localparam logic [BYTE_W-1:0] LEN_CEIL         = 8'd127;
  localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'hFE;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST   = 7'd4;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 7'd80;
  localparam logic              BYPASS_EN_RST    = 1'b1;
  localparam logic [BYTE_W-1:0] BYPASS_CODE_RST  = 8'h88;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_DISCARD    = 3'd0,
    EV_START      = 3'd1,
    EV_LEN_OK     = 3'd2,
    EV_LEN_BAD    = 3'd3,
    EV_DATA       = 3'd4,
    EV_FRAME_GOOD = 3'd5,
    EV_CHECK_FAIL = 3'd6
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE  = 3'd0,
    REG_MIN_LENGTH  = 3'd1,
    REG_MAX_LENGTH  = 3'd2,
    REG_BYPASS_EN   = 3'd3,
    REG_BYPASS_CODE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] computed_check;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] frame_byte;
    event_t            event_res;
  } result_t;

endpackage

>>> sv/uart_frame_parser_xor_fcs_top.sv
// Top level of the UART frame parser: start byte, length byte, data, XOR check.
// Depends on ufp_pkg for types, event codes and register indexes.
//
// The parser takes one received byte per item and gives one result item per byte, at a
// sustained rate of one item per clock cycle while out_tready stays high. An item passes
// an input register and a result register: it is loaded into the input register at the
// edge that accepts it, and its result is registered into the result register once the
// output is free. The whole parse step for a byte is combinational logic between those
// two registers. While a result waits, the input side takes one more item into the input
// register and then holds in_tready low. Configuration registers are written through the
// plain write port and should only change while no item is in flight.
module uart_frame_parser_xor_fcs_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ufp_pkg::BYTE_W-1:0]           in_tdata,   // [7:0] rx_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] event_res, [10:3] frame_byte, [17:11] byte_pos, [24:18] frame_length,
  // [32:25] computed_check, [39:33] zero
  output logic [ufp_pkg::OUT_W-1:0]            out_tdata,
  input  logic                                 cfg_we,
  input  logic [ufp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ufp_pkg::CFG_W-1:0]            cfg_data
);
  import ufp_pkg::*;

  logic [BYTE_W-1:0] start_byte_r;
  logic [LEN_W-1:0]  min_length_r;
  logic [LEN_W-1:0]  max_length_r;
  logic              bypass_en_r;
  logic [BYTE_W-1:0] bypass_code_r;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  result_t           result_r;
  result_t           result_nxt;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [LEN_W-1:0]  taken_r, taken_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;

  logic              out_free;
  logic              xfer;
  logic [LEN_W-1:0]  taken_inc;
  logic [BYTE_W-1:0] xor_with_byte;
  logic              len_bad;
  logic              check_ok;

  assign out_free   = !out_valid_r || out_tready;
  assign xfer       = in_valid_r && out_free;
  assign in_tready  = !in_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, result_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= START_BYTE_RST;
      min_length_r  <= MIN_LENGTH_RST;
      max_length_r  <= MAX_LENGTH_RST;
      bypass_en_r   <= BYPASS_EN_RST;
      bypass_code_r <= BYPASS_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:  start_byte_r  <= cfg_data;
        REG_MIN_LENGTH:  min_length_r  <= cfg_data[LEN_W-1:0];
        REG_MAX_LENGTH:  max_length_r  <= cfg_data[LEN_W-1:0];
        REG_BYPASS_EN:   bypass_en_r   <= cfg_data[0];
        REG_BYPASS_CODE: bypass_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      length_r <= '0;
      taken_r  <= '0;
      xor_r    <= '0;
    end else if (xfer) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      taken_r  <= taken_nxt;
      xor_r    <= xor_nxt;
    end
  end

  assign taken_inc     = taken_r + LEN_W'(1);
  assign xor_with_byte = xor_r ^ in_byte_r;
  assign len_bad       = (in_byte_r < LEN_FLOOR) || (in_byte_r < {1'b0, min_length_r}) ||
                         (in_byte_r > {1'b0, max_length_r}) || (in_byte_r > LEN_CEIL);
  assign check_ok      = (in_byte_r == xor_r) || (bypass_en_r && (in_byte_r == bypass_code_r));

  always_comb begin
    phase_nxt                 = phase_r;
    length_nxt                = length_r;
    taken_nxt                 = taken_r;
    xor_nxt                   = xor_r;
    result_nxt.event_res      = EV_DISCARD;
    result_nxt.frame_byte     = in_byte_r;
    result_nxt.byte_pos       = '0;
    result_nxt.frame_length   = '0;
    result_nxt.computed_check = '0;
    case (phase_r)
      PH_HUNT: begin
        if (in_byte_r == start_byte_r) begin
          phase_nxt                 = PH_LEN;
          length_nxt                = '0;
          taken_nxt                 = LEN_W'(1);
          xor_nxt                   = in_byte_r;
          result_nxt.event_res      = EV_START;
          result_nxt.computed_check = in_byte_r;
        end
      end
      PH_LEN: begin
        result_nxt.byte_pos = LEN_W'(1);
        if (len_bad) begin
          phase_nxt            = PH_HUNT;
          length_nxt           = '0;
          taken_nxt            = '0;
          xor_nxt              = '0;
          result_nxt.event_res = EV_LEN_BAD;
        end else begin
          phase_nxt                 = PH_DATA;
          length_nxt                = in_byte_r[LEN_W-1:0];
          taken_nxt                 = LEN_W'(2);
          xor_nxt                   = xor_with_byte;
          result_nxt.event_res      = EV_LEN_OK;
          result_nxt.frame_length   = in_byte_r[LEN_W-1:0];
          result_nxt.computed_check = xor_with_byte;
        end
      end
      PH_DATA: begin
        taken_nxt                 = taken_inc;
        xor_nxt                   = xor_with_byte;
        result_nxt.event_res      = EV_DATA;
        result_nxt.byte_pos       = taken_r;
        result_nxt.frame_length   = length_r;
        result_nxt.computed_check = xor_with_byte;
        if (({1'b0, taken_inc} + 8'd1) >= {1'b0, length_r}) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_nxt                 = PH_HUNT;
        length_nxt                = '0;
        taken_nxt                 = '0;
        xor_nxt                   = '0;
        result_nxt.event_res      = check_ok ? EV_FRAME_GOOD : EV_CHECK_FAIL;
        result_nxt.byte_pos       = taken_r;
        result_nxt.frame_length   = length_r;
        result_nxt.computed_check = xor_r;
      end
      default: ;
    endcase
  end

  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) |-> (length_r == '0 && taken_r == '0 && xor_r == '0))
    else $error("parser state not cleared while hunting");

  a_len_held: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA || phase_r == PH_CHECK) |-> ({1'b0, length_r} >= LEN_FLOOR))
    else $error("frame length below floor inside a frame");

  a_len_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && xfer && phase_r == PH_LEN && len_bad) |=>
      (phase_r == PH_HUNT && out_valid_r && result_r.event_res == EV_LEN_BAD))
    else $error("rejected length did not return to hunting");

  a_check_end: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && xfer && phase_r == PH_CHECK) |=>
      (phase_r == PH_HUNT && out_valid_r &&
       (result_r.event_res == EV_FRAME_GOOD || result_r.event_res == EV_CHECK_FAIL)))
    else $error("check byte did not close the frame");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for uart_frame_parser_xor_fcs_top: random and directed byte streams
// are scored against a predictor of the start/length/data/XOR-check parser.
// Depends on ufp_pkg and the top level only.
`timescale 1ns / 1ps

module testbench;
  import ufp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_ITEMS   = 90;
  localparam int unsigned MAX_PRINTS    = 200;

  class frame_scoreboard;
    logic [BYTE_W-1:0] start_byte;
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;
    logic              byp_en;
    logic [BYTE_W-1:0] byp_code;
    phase_t            phase;
    logic [LEN_W-1:0]  len_held;
    logic [LEN_W-1:0]  taken;
    logic [BYTE_W-1:0] acc;
    result_t           events_due[$];
    int                errors;

    function new();
      start_byte = START_BYTE_RST;
      min_len    = MIN_LENGTH_RST;
      max_len    = MAX_LENGTH_RST;
      byp_en     = BYPASS_EN_RST;
      byp_code   = BYPASS_CODE_RST;
      phase      = PH_HUNT;
      len_held   = '0;
      taken      = '0;
      acc        = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_START_BYTE:  start_byte = v;
        REG_MIN_LENGTH:  min_len    = v[LEN_W-1:0];
        REG_MAX_LENGTH:  max_len    = v[LEN_W-1:0];
        REG_BYPASS_EN:   byp_en     = v[0];
        REG_BYPASS_CODE: byp_code   = v;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      result_t r;
      r = '0;
      r.event_res  = EV_DISCARD;
      r.frame_byte = b;
      case (phase)
        PH_HUNT: begin
          if (b == start_byte) begin
            acc              = b;
            taken            = 7'd1;
            len_held         = '0;
            phase            = PH_LEN;
            r.event_res      = EV_START;
            r.computed_check = acc;
          end
        end
        PH_LEN: begin
          r.byte_pos = 7'd1;
          if (b < LEN_FLOOR || b < {1'b0, min_len} || b > {1'b0, max_len} || b > LEN_CEIL) begin
            phase       = PH_HUNT;
            taken       = '0;
            len_held    = '0;
            acc         = '0;
            r.event_res = EV_LEN_BAD;
          end else begin
            len_held         = b[LEN_W-1:0];
            acc              = acc ^ b;
            taken            = 7'd2;
            phase            = PH_DATA;
            r.event_res      = EV_LEN_OK;
            r.frame_length   = len_held;
            r.computed_check = acc;
          end
        end
        PH_DATA: begin
          r.byte_pos       = taken;
          r.frame_length   = len_held;
          acc              = acc ^ b;
          r.computed_check = acc;
          taken            = taken + 7'd1;
          if ({1'b0, taken} + 8'd1 >= {1'b0, len_held}) phase = PH_CHECK;
          r.event_res = EV_DATA;
        end
        default: begin
          r.byte_pos       = taken;
          r.frame_length   = len_held;
          r.computed_check = acc;
          if (b == acc || (byp_en && b == byp_code)) r.event_res = EV_FRAME_GOOD;
          else r.event_res = EV_CHECK_FAIL;
          phase    = PH_HUNT;
          taken    = '0;
          len_held = '0;
          acc      = '0;
        end
      endcase
      events_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [OUT_W-1:0] d);
      result_t got;
      result_t want;
      got = d[$bits(result_t)-1:0];
      if (events_due.size() == 0) begin
        report($sformatf("unexpected result %h", d));
      end else begin
        want = events_due.pop_front();
        if (got.event_res !== want.event_res)
          report($sformatf("event %0d, expected %0d", got.event_res, want.event_res));
        if (got.frame_byte !== want.frame_byte)
          report($sformatf("frame_byte %h, expected %h", got.frame_byte, want.frame_byte));
        if (got.byte_pos !== want.byte_pos)
          report($sformatf("byte_pos %0d, expected %0d", got.byte_pos, want.byte_pos));
        if (got.frame_length !== want.frame_length)
          report($sformatf("frame_length %0d, expected %0d", got.frame_length,
                           want.frame_length));
        if (got.computed_check !== want.computed_check)
          report($sformatf("computed_check %h, expected %h", got.computed_check,
                           want.computed_check));
        if (d[OUT_W-1:$bits(result_t)] !== '0)
          report($sformatf("padding bits %h not zero", d[OUT_W-1:$bits(result_t)]));
      end
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  bit              calm   = 1'b0;
  int unsigned     cycles = 0;
  frame_scoreboard sb     = new();

  uart_frame_parser_xor_fcs_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= rst_n && (calm || $urandom_range(99) >= 38);
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int ph);
    logic [CFG_W-1:0] sof;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] en;
    logic [CFG_W-1:0] code;
    sof  = CFG_W'($urandom_range(255));
    code = CFG_W'($urandom_range(255));
    en   = 8'd1;
    case (ph)
      0: begin
        sof  = START_BYTE_RST;
        lo   = {1'b0, MIN_LENGTH_RST};
        hi   = {1'b0, MAX_LENGTH_RST};
        code = BYPASS_CODE_RST;
      end
      1: begin
        sof = 8'h00; lo = 8'd4; hi = 8'd4; en = 8'd0; code = 8'h00;
      end
      2: begin
        sof = 8'hFF; lo = 8'd127; hi = 8'd127; code = 8'hFF;
      end
      3: begin
        lo = 8'd4; hi = 8'd127;
      end
      4: begin
        lo = 8'd100; hi = 8'd50;
      end
      default: begin
        lo = CFG_W'($urandom_range(4, 20));
        hi = CFG_W'($urandom_range(int'(lo), 40));
        en = CFG_W'($urandom_range(1));
      end
    endcase
    write_reg(REG_START_BYTE, sof);
    write_reg(REG_MIN_LENGTH, lo);
    write_reg(REG_MAX_LENGTH, hi);
    write_reg(REG_BYPASS_EN, en);
    write_reg(REG_BYPASS_CODE, code);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(inout int sent);
    int               lo;
    int               hi;
    int               flen;
    int               roll;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] d;
    lo   = (sb.min_len < 4) ? 4 : int'(sb.min_len);
    hi   = int'(sb.max_len);
    roll = $urandom_range(99);
    if (roll < 8 || lo > hi) flen = $urandom_range(255);
    else if (roll < 14)      flen = hi;
    else if (roll < 18)      flen = lo;
    else                     flen = $urandom_range(lo, (hi > lo + 10) ? lo + 10 : hi);
    acc = sb.start_byte ^ flen[7:0];
    push_byte(sb.start_byte);
    push_byte(flen[7:0]);
    sent += 2;
    if (flen >= 4 && flen >= sb.min_len && flen <= sb.max_len && flen <= 127) begin
      for (int i = 0; i < flen - 3; i++) begin
        d = BYTE_W'($urandom_range(255));
        acc ^= d;
        push_byte(d);
      end
      roll = $urandom_range(99);
      if (roll < 60)      push_byte(acc);
      else if (roll < 75) push_byte(sb.byp_code);
      else                push_byte(BYTE_W'($urandom_range(255)));
      sent += flen - 2;
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] opening[$];
    int                sent;
    opening = '{8'h00, 8'hFF,
                8'hFE, 8'h04, 8'h5A, 8'hA0,
                8'hFE, 8'h04, 8'h00, 8'h88,
                8'hFE, 8'h04, 8'h11, 8'h00,
                8'hFE, 8'h03,
                8'hFE, 8'hFE,
                8'hFE, 8'h51,
                8'hFE, 8'h05, 8'hFF, 8'h00, 8'h04};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening[i]) push_byte(opening[i]);
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      apply_settings(ph);
      calm = (ph == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 20)
          repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(255)));
        send_frame(sent);
      end
    end
    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ufp_pkg.sv
sv/uart_frame_parser_xor_fcs_top.sv
verif/testbench.sv
